[rtl/core/bhps_pkg.sv]
package bhps_pkg;

    localparam logic [7:0] CH_DICT  = 8'h64;
    localparam logic [7:0] CH_LIST  = 8'h6C;
    localparam logic [7:0] CH_END   = 8'h65;
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] MODE_STRUCT  = 3'd0;
    localparam logic [2:0] MODE_DIGITS  = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_INTEGER = 3'd3;
    localparam logic [2:0] MODE_PAYLOAD = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       end_of_message;
        logic       header_found;
    } t_out_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       depth_zero;
    } t_scan_status;

endpackage

[rtl/core/bhps_scan.sv]
module bhps_scan #(
    parameter int LENGTH_BITS = 24,
    parameter int DEPTH_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  bhps_pkg::t_in_item    i_item,
    output bhps_pkg::t_out_item   o_result,
    output bhps_pkg::t_scan_status o_status
);
    import bhps_pkg::*;

    logic [2:0]             r_mode;
    logic [2:0]             n_mode;
    logic [DEPTH_BITS-1:0]  r_depth;
    logic [DEPTH_BITS-1:0]  n_depth;
    logic [LENGTH_BITS-1:0] r_count;
    logic [LENGTH_BITS-1:0] n_count;

    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [LENGTH_BITS+3:0] count_x10;
    logic [LENGTH_BITS-1:0] count_sat;

    always_comb begin
        is_digit  = (i_item.in_byte inside {[CH_ZERO:CH_NINE]});
        digit_val = 4'(i_item.in_byte - CH_ZERO);
        count_x10 = ({4'b0, r_count} << 3) + ({4'b0, r_count} << 1)
                  + {{LENGTH_BITS{1'b0}}, digit_val};
        count_sat = (count_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0)
                  ? {LENGTH_BITS{1'b1}} : count_x10[LENGTH_BITS-1:0];
    end

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_count = r_count;
        case (r_mode)
            MODE_STRUCT: begin
                if (i_item.in_byte == CH_DICT || i_item.in_byte == CH_LIST) begin
                    if (r_depth != {DEPTH_BITS{1'b1}}) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (i_item.in_byte == CH_END) begin
                    if (r_depth != '0) begin
                        n_depth = r_depth - 1'b1;
                        if (r_depth == DEPTH_BITS'(1)) begin
                            n_mode = MODE_PAYLOAD;
                        end
                    end
                end else if (is_digit) begin
                    n_count = {{(LENGTH_BITS-4){1'b0}}, digit_val};
                    n_mode  = MODE_DIGITS;
                end else if (i_item.in_byte == CH_INT) begin
                    n_mode = MODE_INTEGER;
                end
            end
            MODE_DIGITS: begin
                if (is_digit) begin
                    n_count = count_sat;
                end else if (i_item.in_byte == CH_COLON) begin
                    n_mode = (r_count == '0) ? MODE_STRUCT : MODE_STRING;
                end else begin
                    n_count = '0;
                    n_mode  = MODE_STRUCT;
                end
            end
            MODE_STRING: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                if (r_count == '0 || r_count == LENGTH_BITS'(1)) begin
                    n_mode = MODE_STRUCT;
                end
            end
            MODE_INTEGER: begin
                if (i_item.in_byte == CH_END) begin
                    n_mode = MODE_STRUCT;
                end
            end
            MODE_PAYLOAD: begin
                n_mode = MODE_PAYLOAD;
            end
            default: begin
                n_mode = MODE_STRUCT;
            end
        endcase
    end

    always_comb begin
        o_result.out_byte       = i_item.in_byte;
        o_result.is_payload     = (r_mode == MODE_PAYLOAD);
        o_result.end_of_message = i_item.msg_last;
        o_result.header_found   = (n_mode == MODE_PAYLOAD);
        o_status.mode           = r_mode;
        o_status.depth_zero     = (r_depth == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_STRUCT;
            r_depth <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            if (i_item.msg_last) begin
                r_mode  <= MODE_STRUCT;
                r_depth <= '0;
                r_count <= '0;
            end else begin
                r_mode  <= n_mode;
                r_depth <= n_depth;
                r_count <= n_count;
            end
        end
    end

endmodule

[rtl/core/bhps_skid.sv]
module bhps_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bhps_pkg::t_out_item i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bhps_pkg::t_out_item o_data
);
    import bhps_pkg::*;

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;
    logic      push;
    logic      pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
            end
        end else if (push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (push && (pop || !r_main_valid)) begin
            r_main <= i_data;
        end
        if (push && r_main_valid && !pop) begin
            r_skid <= i_data;
        end
    end

endmodule

[rtl/core/bencode_header_payload_splitter_core.sv]
// Bencode header/payload splitter.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one message byte
// per item with a last-byte flag. Output channel (o_out_valid / i_out_ready /
// o_out_item) returns exactly one item per input byte: the byte itself, a
// payload flag (byte follows the close of the first top-level dictionary or list),
// the last-byte flag and a header-found flag that includes the current byte.
// Each result is registered in the output buffer before it is presented.
// Throughput: one byte per cycle while o_in_ready is high; the scan state update is
// a combinational step, and the one-entry carry to the next byte is the scanner's state.
// Reset clears the scanner to structure scanning with zero depth and length,
// and empties the output buffer. The scan state also clears after every
// byte marked last, so each message is scanned on its own.
// When the receiver stalls, the output register plus a skid entry hold up to
// two results; o_in_ready drops only once both are full, and no result is
// ever dropped or repeated.
module bencode_header_payload_splitter_core #(
    parameter int LENGTH_BITS = 24,
    parameter int DEPTH_BITS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bhps_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bhps_pkg::t_out_item o_out_item
);
    import bhps_pkg::*;

    logic         in_accept;
    t_out_item    scan_result;
    t_scan_status scan_status;

    assign in_accept = i_in_valid && o_in_ready;

    bhps_scan #(
        .LENGTH_BITS(LENGTH_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_item  (i_in_item),
        .o_result(scan_result),
        .o_status(scan_status)
    );

    bhps_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_ready(o_in_ready),
        .i_data (scan_result),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_item)
    );

    a_payload_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_payload |-> o_out_item.header_found)
        else $error("payload byte without header found");

    a_not_ready_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.msg_last |=>
            scan_status.mode == MODE_STRUCT && scan_status.depth_zero)
        else $error("scan state not cleared after last byte");

    a_payload_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_status.mode == MODE_PAYLOAD |-> scan_status.depth_zero)
        else $error("payload mode with nonzero depth");

endmodule
